/* rtl/core/tikv_pkg.sv */
// tikv_pkg: shared constants, codes and handshake types for the tab-indented
// name:value tokenizer; used by the controller, the datapath and the top level
package tikv_pkg;

   // character codes
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // scan modes
   localparam logic [2:0] MODE_NAME         = 3'd0;
   localparam logic [2:0] MODE_LINE_REMARK  = 3'd1;
   localparam logic [2:0] MODE_VALUE        = 3'd2;
   localparam logic [2:0] MODE_VALUE_REMARK = 3'd3;
   localparam logic [2:0] MODE_HALT         = 3'd4;

   // token kinds
   localparam logic [2:0] K_ENTER   = 3'd0;
   localparam logic [2:0] K_LEAVE   = 3'd1;
   localparam logic [2:0] K_NAME    = 3'd2;
   localparam logic [2:0] K_VALUE   = 3'd3;
   localparam logic [2:0] K_COMMENT = 3'd4;
   localparam logic [2:0] K_ERROR   = 3'd5;

   // error codes
   localparam logic [1:0] E_BAD_INDENT     = 2'd0;
   localparam logic [1:0] E_SPACE_INDENT   = 2'd1;
   localparam logic [1:0] E_COLON_MISSING  = 2'd2;
   localparam logic [1:0] E_DEPTH_OVERFLOW = 2'd3;

   localparam int          RESULT_CAP = 20;
   localparam int          CNT_W      = 5;
   localparam logic [15:0] LEN_MAX    = 16'hFFFF;

   typedef struct packed {
      logic load;
      logic emit;
      logic last;
   } tikv_cmd_type;

   typedef struct packed {
      logic             step_has_results;
      logic [CNT_W-1:0] plan_count;
   } tikv_status_type;

   function automatic logic is_white(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

endpackage

/* rtl/core/tikv_req_if.sv */
// tikv_req_if: input channel of the tokenizer, one document byte per transaction
// no dependencies
interface tikv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_req;
   logic       last;

   modport source (output valid, output byte_req, output last, input ready);
   modport sink (input valid, input byte_req, input last, output ready);
endinterface

/* rtl/core/tikv_rsp_if.sv */
// tikv_rsp_if: result channel of the tokenizer, one token span per transaction
// no dependencies
interface tikv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] start_res;
   logic [15:0] length;
   logic [1:0]  error_code;
   logic        last_of_run;
   logic        document_end;

   modport source (output valid, output kind, output start_res, output length,
                   output error_code, output last_of_run, output document_end,
                   input ready);
   modport sink (input valid, input kind, input start_res, input length,
                 input error_code, input last_of_run, input document_end,
                 output ready);
endinterface

/* rtl/core/tikv_datapath.sv */
// tikv_datapath: scanner state, per-byte step logic, result plan and output register
// depends on tikv_pkg
module tikv_datapath import tikv_pkg::*; #(
   parameter int MAX_DEPTH   = 16,
   parameter int OFFSET_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      in_byte,
   input  logic            in_last,
   input  tikv_cmd_type    cmd,
   output tikv_status_type status,
   output logic [2:0]      out_kind,
   output logic [15:0]     out_start,
   output logic [15:0]     out_length,
   output logic [1:0]      out_error_code,
   output logic            out_last_of_run,
   output logic            out_document_end
);

   localparam int OB = OFFSET_BITS;
   localparam int DW = $clog2(MAX_DEPTH + 2);
   localparam int TW = DW + 3;

   function automatic logic [15:0] to16(input logic [OB-1:0] x);
      logic [OB+15:0] ext;
      ext = {16'b0, x};
      return ext[15:0];
   endfunction

   // (last - first) mod 2^OB, plus one, saturated to 16 bits
   function automatic logic [15:0] span_len(input logic [OB-1:0] first,
                                            input logic [OB-1:0] lastp);
      logic [OB-1:0]  diff;
      logic [OB:0]    d;
      logic [OB+16:0] ext;
      diff = lastp - first;
      d    = {1'b0, diff} + {{OB{1'b0}}, 1'b1};
      ext  = {16'b0, d};
      if (ext[OB+16:16] != '0) begin
         return LEN_MAX;
      end
      return ext[15:0];
   endfunction

   // scanner state
   logic [2:0]    mode_ff, mode_in;
   logic [DW-1:0] tab_ff, tab_in;
   logic [DW-1:0] com_ff, com_in;
   logic          may_ff, may_in;
   logic [OB-1:0] pos_ff;
   logic          ks_ff, ks_in;
   logic [OB-1:0] kstart_ff, kstart_in;
   logic [OB-1:0] klast_ff, klast_in;
   logic          vs_ff, vs_in;
   logic [OB-1:0] vf_ff, vf_in;
   logic [OB-1:0] vl_ff, vl_in;
   logic [OB-1:0] rs_ff, rs_in;
   logic [15:0]   rl_ff, rl_in;

   // plan of the step being computed
   logic          np_enter;
   logic [DW-1:0] np_lead;
   logic          np_name;
   logic [15:0]   np_name_start;
   logic [15:0]   np_name_len;
   logic          np_com;
   logic          np_val;
   logic          np_err;
   logic [1:0]    np_err_code;
   logic [DW-1:0] np_tail;
   logic [TW-1:0] np_total;
   logic [CNT_W-1:0] np_count;

   // stored plan, drained one result per emit
   logic          p_enter_ff, p_enter_in;
   logic [DW-1:0] p_lead_ff, p_lead_in;
   logic          p_name_ff, p_name_in;
   logic [15:0]   p_name_start_ff, p_name_len_ff;
   logic          p_com_ff, p_com_in;
   logic [15:0]   p_com_start_ff, p_com_len_ff;
   logic          p_val_ff, p_val_in;
   logic [15:0]   p_val_start_ff, p_val_len_ff;
   logic          p_err_ff, p_err_in;
   logic [15:0]   p_err_start_ff;
   logic [1:0]    p_err_code_ff;
   logic [DW-1:0] p_tail_ff, p_tail_in;
   logic          p_fin_ff;
   logic [CNT_W-1:0] p_count_ff;

   // output register
   logic [2:0]  o_kind_ff;
   logic [15:0] o_start_ff;
   logic [15:0] o_len_ff;
   logic [1:0]  o_code_ff;
   logic        o_lor_ff;
   logic        o_de_ff;

   logic [2:0]  sel_kind;
   logic [15:0] sel_start;
   logic [15:0] sel_len;
   logic [1:0]  sel_code;

   logic        deeper;
   logic        next_level;
   logic        white;
   logic [15:0] name_span;

   assign deeper     = tab_ff > com_ff;
   assign next_level = {1'b0, tab_ff} == ({1'b0, com_ff} + {{DW{1'b0}}, 1'b1});
   assign white      = is_white(in_byte);
   assign name_span  = span_len(kstart_ff, klast_ff);

   // one step of the scanner
   always_comb begin
      mode_in       = mode_ff;
      tab_in        = tab_ff;
      com_in        = com_ff;
      may_in        = may_ff;
      ks_in         = ks_ff;
      kstart_in     = kstart_ff;
      klast_in      = klast_ff;
      vs_in         = vs_ff;
      vf_in         = vf_ff;
      vl_in         = vl_ff;
      rs_in         = rs_ff;
      rl_in         = rl_ff;
      np_enter      = 1'b0;
      np_lead       = '0;
      np_name       = 1'b0;
      np_name_start = to16(pos_ff);
      np_name_len   = '0;
      np_com        = 1'b0;
      np_val        = 1'b0;
      np_err        = 1'b0;
      np_err_code   = E_BAD_INDENT;
      np_tail       = '0;
      unique case (mode_ff)
         MODE_NAME: begin
            if (in_byte == CH_HASH) begin
               ks_in   = 1'b0;
               tab_in  = '0;
               may_in  = 1'b0;
               rs_in   = pos_ff + {{(OB-1){1'b0}}, 1'b1};
               rl_in   = '0;
               mode_in = MODE_LINE_REMARK;
            end else if (in_byte == CH_COLON) begin
               if ((deeper && !may_ff) || (deeper && !next_level)) begin
                  np_err      = 1'b1;
                  np_err_code = E_BAD_INDENT;
               end else if (tab_ff > DW'(MAX_DEPTH)) begin
                  np_err      = 1'b1;
                  np_err_code = E_DEPTH_OVERFLOW;
               end else begin
                  if (deeper) begin
                     np_enter = 1'b1;
                  end else begin
                     np_lead = com_ff - tab_ff;
                  end
                  com_in  = tab_ff;
                  tab_in  = '0;
                  np_name = 1'b1;
                  if (ks_ff) begin
                     np_name_start = to16(kstart_ff);
                     np_name_len   = name_span;
                  end
                  ks_in   = 1'b0;
                  may_in  = 1'b1;
                  vs_in   = 1'b0;
                  mode_in = MODE_VALUE;
               end
            end else if (in_byte == CH_SPACE && !ks_ff) begin
               np_err      = 1'b1;
               np_err_code = E_SPACE_INDENT;
            end else if (in_byte == CH_TAB && !ks_ff) begin
               if (tab_ff < DW'(MAX_DEPTH + 1)) begin
                  tab_in = tab_ff + {{(DW-1){1'b0}}, 1'b1};
               end
            end else if (in_byte == CH_LF && ks_ff) begin
               np_err      = 1'b1;
               np_err_code = E_COLON_MISSING;
            end else if (ks_ff) begin
               if (!white) begin
                  klast_in = pos_ff;
               end
            end else if (!white) begin
               ks_in     = 1'b1;
               kstart_in = pos_ff;
               klast_in  = pos_ff;
            end
         end
         MODE_LINE_REMARK, MODE_VALUE_REMARK: begin
            if (in_byte == CH_LF) begin
               np_com  = rl_ff != '0;
               np_val  = (mode_ff == MODE_VALUE_REMARK) && vs_ff;
               mode_in = MODE_NAME;
            end else if (rl_ff != LEN_MAX) begin
               rl_in = rl_ff + 16'd1;
            end
         end
         MODE_VALUE: begin
            if (in_byte == CH_LF) begin
               np_val  = vs_ff;
               mode_in = MODE_NAME;
            end else if (in_byte == CH_HASH) begin
               rs_in   = pos_ff + {{(OB-1){1'b0}}, 1'b1};
               rl_in   = '0;
               mode_in = MODE_VALUE_REMARK;
            end else if (!white) begin
               if (!vs_ff) begin
                  vs_in = 1'b1;
                  vf_in = pos_ff;
               end
               vl_in = pos_ff;
            end
         end
         default: begin
         end
      endcase
      if (np_err) begin
         mode_in = MODE_HALT;
      end
      // end of document closes what is open
      if (in_last) begin
         if (mode_in == MODE_NAME) begin
            if (ks_in) begin
               np_err      = 1'b1;
               np_err_code = E_COLON_MISSING;
            end else begin
               np_tail = com_in;
            end
         end else if (mode_in != MODE_HALT) begin
            np_com  = (rl_in != '0) &&
                      (mode_in == MODE_LINE_REMARK || mode_in == MODE_VALUE_REMARK);
            np_val  = (mode_in != MODE_LINE_REMARK) && vs_in;
            np_tail = com_in;
         end
      end
      np_total = TW'(np_enter) + TW'(np_lead) + TW'(np_name) + TW'(np_com) +
                 TW'(np_val) + TW'(np_err) + TW'(np_tail);
      np_count = (np_total > TW'(RESULT_CAP)) ? CNT_W'(RESULT_CAP) : np_total[CNT_W-1:0];
   end

   // pick the next pending result in token order
   always_comb begin
      p_enter_in = p_enter_ff;
      p_lead_in  = p_lead_ff;
      p_name_in  = p_name_ff;
      p_com_in   = p_com_ff;
      p_val_in   = p_val_ff;
      p_err_in   = p_err_ff;
      p_tail_in  = p_tail_ff;
      sel_kind   = K_LEAVE;
      sel_start  = '0;
      sel_len    = '0;
      sel_code   = E_BAD_INDENT;
      if (p_enter_ff) begin
         sel_kind   = K_ENTER;
         p_enter_in = 1'b0;
      end else if (p_lead_ff != '0) begin
         p_lead_in = p_lead_ff - {{(DW-1){1'b0}}, 1'b1};
      end else if (p_name_ff) begin
         sel_kind  = K_NAME;
         sel_start = p_name_start_ff;
         sel_len   = p_name_len_ff;
         p_name_in = 1'b0;
      end else if (p_com_ff) begin
         sel_kind  = K_COMMENT;
         sel_start = p_com_start_ff;
         sel_len   = p_com_len_ff;
         p_com_in  = 1'b0;
      end else if (p_val_ff) begin
         sel_kind  = K_VALUE;
         sel_start = p_val_start_ff;
         sel_len   = p_val_len_ff;
         p_val_in  = 1'b0;
      end else if (p_err_ff) begin
         sel_kind  = K_ERROR;
         sel_start = p_err_start_ff;
         sel_code  = p_err_code_ff;
         p_err_in  = 1'b0;
      end else if (p_tail_ff != '0) begin
         p_tail_in = p_tail_ff - {{(DW-1){1'b0}}, 1'b1};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NAME;
         tab_ff     <= '0;
         com_ff     <= '0;
         may_ff     <= 1'b0;
         pos_ff     <= '0;
         ks_ff      <= 1'b0;
         vs_ff      <= 1'b0;
         rl_ff      <= '0;
         p_enter_ff <= 1'b0;
         p_lead_ff  <= '0;
         p_name_ff  <= 1'b0;
         p_com_ff   <= 1'b0;
         p_val_ff   <= 1'b0;
         p_err_ff   <= 1'b0;
         p_tail_ff  <= '0;
         p_fin_ff   <= 1'b0;
         p_count_ff <= '0;
      end else begin
         if (cmd.load) begin
            if (in_last) begin
               mode_ff <= MODE_NAME;
               tab_ff  <= '0;
               com_ff  <= '0;
               may_ff  <= 1'b0;
               pos_ff  <= '0;
               ks_ff   <= 1'b0;
               vs_ff   <= 1'b0;
               rl_ff   <= '0;
            end else begin
               mode_ff <= mode_in;
               tab_ff  <= tab_in;
               com_ff  <= com_in;
               may_ff  <= may_in;
               pos_ff  <= pos_ff + {{(OB-1){1'b0}}, 1'b1};
               ks_ff   <= ks_in;
               vs_ff   <= vs_in;
               rl_ff   <= rl_in;
            end
            p_enter_ff <= np_enter;
            p_lead_ff  <= np_lead;
            p_name_ff  <= np_name;
            p_com_ff   <= np_com;
            p_val_ff   <= np_val;
            p_err_ff   <= np_err;
            p_tail_ff  <= np_tail;
            p_fin_ff   <= in_last;
            p_count_ff <= np_count;
         end else if (cmd.emit) begin
            p_enter_ff <= p_enter_in;
            p_lead_ff  <= p_lead_in;
            p_name_ff  <= p_name_in;
            p_com_ff   <= p_com_in;
            p_val_ff   <= p_val_in;
            p_err_ff   <= p_err_in;
            p_tail_ff  <= p_tail_in;
         end
      end
   end

   // span payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kstart_ff       <= kstart_in;
         klast_ff        <= klast_in;
         vf_ff           <= vf_in;
         vl_ff           <= vl_in;
         rs_ff           <= rs_in;
         p_name_start_ff <= np_name_start;
         p_name_len_ff   <= np_name_len;
         p_com_start_ff  <= to16(rs_in);
         p_com_len_ff    <= rl_in;
         p_val_start_ff  <= to16(vf_in);
         p_val_len_ff    <= span_len(vf_in, vl_in);
         p_err_start_ff  <= to16(pos_ff);
         p_err_code_ff   <= np_err_code;
      end
      if (cmd.emit) begin
         o_kind_ff  <= sel_kind;
         o_start_ff <= sel_start;
         o_len_ff   <= sel_len;
         o_code_ff  <= sel_code;
         o_lor_ff   <= cmd.last;
         o_de_ff    <= cmd.last & p_fin_ff;
      end
   end

   assign status.step_has_results = np_total != '0;
   assign status.plan_count       = p_count_ff;

   assign out_kind         = o_kind_ff;
   assign out_start        = o_start_ff;
   assign out_length       = o_len_ff;
   assign out_error_code   = o_code_ff;
   assign out_last_of_run  = o_lor_ff;
   assign out_document_end = o_de_ff;

endmodule

/* rtl/core/tikv_controller.sv */
// tikv_controller: accept/emit sequencer and result valid flag
// depends on tikv_pkg
module tikv_controller import tikv_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  tikv_status_type status,
   output tikv_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   always_comb begin
      req_ready = state_ff == ST_IDLE;
      out_free  = !rsp_valid_ff || rsp_ready;
      cmd.load  = req_valid && req_ready;
      cmd.emit  = (state_ff == ST_EMIT) && out_free;
      cmd.last  = (idx_ff + CNT_W'(1)) == status.plan_count;
      state_in  = state_ff;
      idx_in    = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load && status.step_has_results) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (cmd.emit) begin
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/tab_indented_key_value_tokenizer_top.sv */
// tab_indented_key_value_tokenizer_top: byte-in, token-span-out tokenizer
// depends on tikv_pkg, tikv_req_if, tikv_rsp_if, tikv_controller, tikv_datapath
//
//   channel   dir  handshake        payload
//   req_chan  in   valid/ready      byte_req[7:0], last
//   rsp_chan  out  valid/ready      kind[2:0], start_res[15:0], length[15:0],
//                                   error_code[1:0], last_of_run, document_end
//
// a byte that yields tokens is followed by the controller draining the result
// plan one transaction per cycle while the rsp side is not stalled, through
// the single output register
// req ready drops only while a plan drains; a held result does not block the
// next byte, and a stalled rsp side holds the plan in place
// synchronous active-high reset returns the scanner to name scanning at offset 0
module tab_indented_key_value_tokenizer_top import tikv_pkg::*; #(
   parameter int MAX_DEPTH   = 16,
   parameter int OFFSET_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   tikv_req_if.sink   req_chan,
   tikv_rsp_if.source rsp_chan
);

   // command and status between sequencer and datapath
   tikv_cmd_type    cmd;
   tikv_status_type status;

   // result payload straight from the datapath output register
   logic [2:0]  dp_kind;
   logic [15:0] dp_start;
   logic [15:0] dp_length;
   logic [1:0]  dp_error_code;
   logic        dp_last_of_run;
   logic        dp_document_end;
   logic        ctl_req_ready;
   logic        ctl_rsp_valid;

   tikv_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctl_req_ready),
      .rsp_valid (ctl_rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tikv_datapath #(
      .MAX_DEPTH   (MAX_DEPTH),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .in_byte          (req_chan.byte_req),
      .in_last          (req_chan.last),
      .cmd              (cmd),
      .status           (status),
      .out_kind         (dp_kind),
      .out_start        (dp_start),
      .out_length       (dp_length),
      .out_error_code   (dp_error_code),
      .out_last_of_run  (dp_last_of_run),
      .out_document_end (dp_document_end)
   );

   // channel hookup
   assign req_chan.ready        = ctl_req_ready;
   assign rsp_chan.valid        = ctl_rsp_valid;
   assign rsp_chan.kind         = dp_kind;
   assign rsp_chan.start_res    = dp_start;
   assign rsp_chan.length       = dp_length;
   assign rsp_chan.error_code   = dp_error_code;
   assign rsp_chan.last_of_run  = dp_last_of_run;
   assign rsp_chan.document_end = dp_document_end;

endmodule
